@@ design/sliding_energy_ratio_picker_unit_macros.svh @@
// Assertion macros used by the energy ratio picker unit module.
// Depends on nothing; included by files that carry assertions.
`ifndef SLIDING_ENERGY_RATIO_PICKER_UNIT_MACROS_SVH
`define SLIDING_ENERGY_RATIO_PICKER_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SERP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequence is checked in the next cycle.
`define SERP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ design/serp_pkg.sv @@
// Shared types and constants for the energy ratio picker.
// No dependencies.
package serp_pkg;
    localparam int unsigned MAX_SAMPLES = 4096;
    localparam int unsigned MAX_WINDOW  = 1024;
    localparam int unsigned CfgW = 11;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FALLBACK = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_UNDEF = 2'd3;
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_SPLIT = 2'd1;
    localparam logic [1:0] REG_LONG = 2'd2;
    localparam logic [1:0] REG_SHORT = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_SUM1, S_SUM2, S_PREP, S_MUL, S_DIV, S_OUT
    } ctl_state_t;

    // Request from the controller to the divider.
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } div_rsp_t;
endpackage

@@ design/serp_div.sv @@
// Restoring Q16.16 divider, one quotient bit per cycle, saturating.
// Depends on serp_pkg.
module serp_div
    import serp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    // Quotient of n*65536/d has 80 bits; saturate when the top 48 are nonzero.
    logic [79:0] num_reg, num_next;
    logic [63:0] den_reg, den_next;
    logic [64:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        sat_reg, sat_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        sat_next  = sat_reg;
        done_next = 1'b0;
        trial     = {rem_reg[63:0], num_reg[79]};
        if (req.start)
        begin
            num_next  = {req.num, 16'd0};
            den_next  = req.den;
            rem_next  = '0;
            cnt_next  = 7'd80;
            busy_next = 1'b1;
            sat_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[78:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = trial - {1'b0, den_reg};
                num_next[0] = 1'b1;
                if (cnt_reg > 7'd32)
                begin
                    sat_next = 1'b1;
                end
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        sat_reg <= sat_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = sat_reg ? 32'hFFFF_FFFF : num_reg[31:0];
endmodule

@@ design/sliding_energy_ratio_picker_unit.sv @@
// Energy ratio picker: loads trace samples into a sample memory and, for each
// compute word, sums squared samples over the windows one memory read per
// cycle, then divides with a bit-serial divider. A compute word raises m_tvalid
// once both window sums, read through the single memory read port, and (unless
// the result is undefined) the 80-step divide are done; a compute word whose
// windows run past the trace raises m_tvalid in the cycle after acceptance, and
// load words are accepted back to back. No new word is taken while a result waits.
// Depends on serp_pkg, serp_div and the macros header.
`include "sliding_energy_ratio_picker_unit_macros.svh"
module sliding_energy_ratio_picker_unit
    import serp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // sample[15:0], start_index[27:16], zeros
    input  logic [1:0]  s_tuser,  // opcode[0], first_sample[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // ratio[31:0], pick_position[43:32], status[45:44]
);
    localparam int unsigned AW = $clog2(MAX_SAMPLES);
    localparam int unsigned CW = AW + 1;

    logic            mode_reg;
    logic [CfgW-1:0] split_reg, long_reg, short_reg;

    logic [15:0] mem [MAX_SAMPLES];
    logic [15:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic        rd_en;

    logic [CW-1:0] count_reg, count_next;
    logic [42:0]   energy_reg, energy_next;

    ctl_state_t state_reg, state_next;
    logic [12:0] ptr_reg, ptr_next;       // absolute read index
    logic [12:0] left_reg, left_next;     // reads remaining in this window
    logic        pend_reg, pend_next;     // read data arrives this cycle
    logic [41:0] acc_reg, acc_next;
    logic [41:0] e1_reg, e1_next;         // before / long energy
    logic [41:0] e2_reg, e2_next;         // after / short energy
    logic [12:0] w_reg, w_next, s_reg, s_next;
    logic [31:0] ratio_reg, ratio_next;
    logic [11:0] pos_reg, pos_next;
    logic [1:0]  status_reg, status_next;
    logic        ovalid_reg, ovalid_next;
    logic [63:0] mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic [63:0] num_reg, num_next, den_reg, den_next;
    logic [12:0] fa_reg, fa_next, fb_reg, fb_next;
    div_req_t    dreq;
    div_rsp_t    drsp;

    logic        in_acc, wr_en;
    logic [12:0] w_cl, l_cl, s_cl, start13, pad;
    logic [13:0] end14;
    logic signed [15:0] smp;
    logic [31:0] sq;

    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[3:2])
            REG_MODE:  prdata = {31'd0, mode_reg};
            REG_SPLIT: prdata = {21'd0, split_reg};
            REG_LONG:  prdata = {21'd0, long_reg};
            REG_SHORT: prdata = {21'd0, short_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            split_reg <= CfgW'(100);
            long_reg  <= CfgW'(100);
            short_reg <= CfgW'(20);
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_MODE:  mode_reg  <= pwdata[0];
                REG_SPLIT: split_reg <= pwdata[CfgW-1:0];
                REG_LONG:  long_reg  <= pwdata[CfgW-1:0];
                REG_SHORT: short_reg <= pwdata[CfgW-1:0];
                default:   ;
            endcase
        end
    end

    function automatic logic [12:0] clampw(input logic [CfgW-1:0] v, input logic [12:0] hi);
        logic [12:0] r;
        r = {2'd0, v};
        if (r == 13'd0) r = 13'd1;
        if (r > hi) r = hi;
        return r;
    endfunction

    assign w_cl    = clampw(split_reg, 13'(MAX_WINDOW));
    assign l_cl    = clampw(long_reg, 13'(MAX_WINDOW));
    assign s_cl    = clampw(short_reg, l_cl);
    assign start13 = {1'b0, s_tdata[27:16]};
    assign s_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign in_acc  = s_tvalid && s_tready;

    // Load path: write at the current count, or at zero for a first sample.
    always_comb
    begin
        count_next  = count_reg;
        energy_next = energy_reg;
        wr_en       = 1'b0;
        smp         = s_tdata[15:0];
        sq          = 32'($signed(smp) * $signed(smp));
        if (in_acc && !s_tuser[0])
        begin
            if (s_tuser[1])
            begin
                count_next  = '0;
                energy_next = '0;
            end
            if (count_next < CW'(MAX_SAMPLES))
            begin
                wr_en       = 1'b1;
                count_next  = count_next + CW'(1);
                energy_next = energy_next + {11'd0, sq};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s_tuser[1] ? '0 : count_reg[AW-1:0]] <= s_tdata[15:0];
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ptr_next = ptr_reg; left_next = left_reg; pend_next = 1'b0;
        acc_next = acc_reg; e1_next = e1_reg; e2_next = e2_reg;
        w_next = w_reg; s_next = s_reg;
        ratio_next = ratio_reg; pos_next = pos_reg; status_next = status_reg;
        ovalid_next = ovalid_reg && !m_tready;
        mul_a_next = mul_a_reg; mul_b_next = mul_b_reg;
        num_next = num_reg; den_next = den_reg;
        fa_next = fa_reg; fb_next = fb_reg;
        dreq = '{start: 1'b0, num: num_reg, den: den_reg};
        rd_en = 1'b0;
        rd_addr = ptr_reg[AW-1:0];
        end14 = '0;
        pad = '0;
        if (pend_reg)
        begin
            acc_next = acc_reg
                       + {10'd0, 32'($signed(rd_data_reg) * $signed(rd_data_reg))};
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && s_tuser[0])
                begin
                    acc_next = '0;
                    ratio_next = '0;
                    status_next = ST_OK;
                    if (!mode_reg)
                    begin
                        pos_next = 12'(start13 + w_cl);
                        end14 = {1'b0, start13} + {w_cl, 1'b0};
                        w_next = w_cl; s_next = w_cl;
                        ptr_next = start13; left_next = w_cl;
                    end
                    else
                    begin
                        pos_next = 12'(start13 + l_cl - 13'd1);
                        end14 = {1'b0, start13} + {1'b0, l_cl};
                        w_next = l_cl; s_next = s_cl;
                        ptr_next = start13; left_next = l_cl;
                    end
                    if (end14 > {{(14-CW){1'b0}}, count_reg})
                    begin
                        status_next = ST_RANGE;
                        ovalid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SUM1;
                    end
                end
            end
            S_SUM1, S_SUM2:
            begin
                if (left_reg != 13'd0)
                begin
                    rd_en = 1'b1;
                    pend_next = 1'b1;
                    ptr_next = ptr_reg + 13'd1;
                    left_next = left_reg - 13'd1;
                end
                else if (!pend_reg)
                begin
                    if (state_reg == S_SUM1)
                    begin
                        e1_next = acc_reg;
                        acc_next = '0;
                        state_next = S_SUM2;
                        left_next = s_reg;
                        ptr_next = mode_reg ? (ptr_reg - s_reg) : ptr_reg;
                    end
                    else
                    begin
                        e2_next = acc_reg;
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                pad = (count_reg > CW'({w_reg, 1'b0})) ? 13'(count_reg) : 13'({w_reg, 1'b0});
                if (e1_reg != '0)
                begin
                    mul_a_next = {22'd0, e2_reg}; fa_next = mode_reg ? w_reg : 13'd1;
                    mul_b_next = {22'd0, e1_reg}; fb_next = mode_reg ? s_reg : 13'd1;
                    state_next = S_MUL;
                end
                else if (energy_reg == '0)
                begin
                    status_next = ST_UNDEF;
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    status_next = ST_FALLBACK;
                    mul_a_next = {22'd0, e2_reg}; fa_next = pad;
                    mul_b_next = {21'd0, energy_reg}; fb_next = mode_reg ? s_reg : 13'd1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                num_next = 64'(mul_a_reg[41:0] * fa_reg);
                den_next = 64'(mul_b_reg[42:0] * fb_reg);
                state_next = S_DIV;
                pend_next = 1'b1;
            end
            S_DIV:
            begin
                dreq.start = pend_reg;
                if (drsp.done)
                begin
                    ratio_next = drsp.quo;
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    serp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
            count_reg  <= '0;
            energy_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            pend_reg   <= pend_next;
            count_reg  <= count_next;
            energy_reg <= energy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next; left_reg <= left_next; acc_reg <= acc_next;
        e1_reg <= e1_next; e2_reg <= e2_next; w_reg <= w_next; s_reg <= s_next;
        ratio_reg <= ratio_next; pos_reg <= pos_next; status_reg <= status_next;
        mul_a_reg <= mul_a_next; mul_b_reg <= mul_b_next;
        num_reg <= num_next; den_reg <= den_next; fa_reg <= fa_next; fb_reg <= fb_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {2'd0, status_reg, pos_reg, ratio_reg};

    `SERP_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !s_tready, "accept while busy")
    `SERP_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(MAX_SAMPLES), "count overflow")
    `SERP_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
endmodule

@@ bench/sliding_energy_ratio_picker_unit_test.sv @@
// Self-checking bench for the energy ratio picker: streams load and ratio words,
// predicts every ratio word in a scoreboard class and compares field by field.
// Depends on serp_pkg and the sliding_energy_ratio_picker_unit RTL.
module sliding_energy_ratio_picker_unit_test;
    import serp_pkg::*;

    localparam bit OP_LOAD  = 1'b0;
    localparam bit OP_RATIO = 1'b1;
    localparam int unsigned STORE_DEPTH = 4096;
    localparam int unsigned WIN_MAX = 1024;
    localparam int unsigned SILENCE_LIMIT = 20000;
    localparam int unsigned LONG_HOLD = 3000;

    typedef struct {
        logic [31:0] ratio;
        logic [11:0] pos;
        logic [1:0]  status;
    } pick_t;

    class ratio_scoreboard;
        logic signed [15:0] trace_mem [STORE_DEPTH];
        int unsigned trace_len;
        longint unsigned trace_energy;
        bit mode;
        int unsigned split_w, long_w, short_w;
        pick_t expected_q[$];
        int errors;

        function new();
            trace_len = 0;
            trace_energy = 0;
            mode = 0;
            split_w = 100;
            long_w = 100;
            short_w = 20;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_MODE:  mode = v[0];
                REG_SPLIT: split_w = 32'(v[10:0]);
                REG_LONG:  long_w = 32'(v[10:0]);
                REG_SHORT: short_w = 32'(v[10:0]);
                default: ;
            endcase
        endfunction

        function int unsigned clamp_len(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function longint unsigned span_energy(int unsigned from, int unsigned len);
            longint unsigned acc;
            longint sv;
            acc = 0;
            for (int unsigned i = 0; i < len; i++)
            begin
                sv = 64'(trace_mem[from + i]);
                acc += longint'(sv * sv);
            end
            return acc;
        endfunction

        // Q16.16 quotient, truncated, saturated when the integer part overflows.
        function logic [31:0] q16_ratio(longint unsigned n, longint unsigned d);
            longint unsigned q, r;
            logic [15:0] frac;
            q = n / d;
            if (q > 64'hFFFF) return 32'hFFFF_FFFF;
            r = n % d;
            frac = 0;
            for (int k = 0; k < 16; k++)
            begin
                r = r << 1;
                frac = frac << 1;
                if (r >= d)
                begin
                    r -= d;
                    frac[0] = 1'b1;
                end
            end
            return {q[15:0], frac};
        endfunction

        function void note_word(bit op, logic [15:0] smp, bit first, logic [11:0] start);
            pick_t p;
            int unsigned w, l, s;
            longint unsigned e_a, e_b, pad, lim;
            longint sv;
            if (op == OP_LOAD)
            begin
                if (first)
                begin
                    trace_len = 0;
                    trace_energy = 0;
                end
                if (trace_len < STORE_DEPTH)
                begin
                    trace_mem[trace_len] = smp;
                    trace_len++;
                    sv = 64'($signed(smp));
                    trace_energy += longint'(sv * sv);
                end
                return;
            end
            p.ratio = 0;
            p.status = ST_OK;
            if (!mode)
            begin
                w = clamp_len(split_w, WIN_MAX);
                p.pos = 12'(start + w);
                lim = 2 * w;
                pad = (trace_len > lim) ? trace_len : lim;
                if (start + 2 * w > trace_len)
                    p.status = ST_RANGE;
                else
                begin
                    e_a = span_energy(start, w);
                    e_b = span_energy(start + w, w);
                    if (e_a != 0)
                        p.ratio = q16_ratio(e_b, e_a);
                    else if (trace_energy == 0)
                        p.status = ST_UNDEF;
                    else
                    begin
                        p.ratio = q16_ratio(e_b * pad, trace_energy);
                        p.status = ST_FALLBACK;
                    end
                end
            end
            else
            begin
                l = clamp_len(long_w, WIN_MAX);
                s = clamp_len(short_w, l);
                p.pos = 12'(start + l - 1);
                lim = 2 * l;
                pad = (trace_len > lim) ? trace_len : lim;
                if (start + l > trace_len)
                    p.status = ST_RANGE;
                else
                begin
                    e_a = span_energy(start, l);
                    e_b = span_energy(start + l - s, s);
                    if (e_a != 0)
                        p.ratio = q16_ratio(e_b * l, e_a * s);
                    else if (trace_energy == 0)
                        p.status = ST_UNDEF;
                    else
                    begin
                        p.ratio = q16_ratio(e_b * pad, trace_energy * s);
                        p.status = ST_FALLBACK;
                    end
                end
            end
            expected_q.push_back(p);
        endfunction

        function void check_word(logic [47:0] d);
            pick_t p;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result word %h", d);
                errors++;
                return;
            end
            p = expected_q.pop_front();
            if (d[31:0] !== p.ratio)
            begin
                $error("ratio: expected %h, actual %h", p.ratio, d[31:0]);
                errors++;
            end
            if (d[43:32] !== p.pos)
            begin
                $error("pick_position: expected %0d, actual %0d", p.pos, d[43:32]);
                errors++;
            end
            if (d[45:44] !== p.status)
            begin
                $error("status: expected %0d, actual %0d", p.status, d[45:44]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;  // sample[15:0], start_index[27:16], zeros
    logic [1:0]  s_tuser;  // opcode[0], first_sample[1]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;  // ratio[31:0], pick_position[43:32], status[45:44]

    ratio_scoreboard sb;
    bit quiet;
    bit hold_req;
    int unsigned silent_cycles;
    int zero_run;

    sliding_energy_ratio_picker_unit dut (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Every accepted word goes through the scoreboard here.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_word(s_tuser[0], s_tdata[15:0], s_tuser[1], s_tdata[27:16]);
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            silent_cycles <= 0;
        else
            silent_cycles <= silent_cycles + 1;
        if (silent_cycles >= SILENCE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 0;
            end
            else if (quiet)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    end

    task automatic send_word(bit op, logic [15:0] smp, bit first, logic [11:0] start);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, start, smp};
        s_tuser <= {first, op};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic load(logic [15:0] smp, bit first = 1'b0);
        send_word(OP_LOAD, smp, first, 12'($urandom));
    endtask

    task automatic ratio_at(logic [11:0] start);
        send_word(OP_RATIO, 16'($urandom), 1'($urandom), start);
    endtask

    // Registers change only once every ratio word is back and loads have settled.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    function automatic logic [15:0] pick_sample();
        if (zero_run > 0)
        begin
            zero_run--;
            return 16'h0000;
        end
        if ($urandom_range(0, 19) == 0)
            zero_run = $urandom_range(1, 30);
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n_words);
        int unsigned l;
        wait_idle();
        write_reg(REG_MODE, $urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: write_reg(REG_SPLIT, 32'd0);
            1: write_reg(REG_SPLIT, $urandom_range(40, 80));
            default: write_reg(REG_SPLIT, $urandom_range(1, 24));
        endcase
        l = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 48);
        write_reg(REG_LONG, l);
        write_reg(REG_SHORT, $urandom_range(0, l + 5));
        load(pick_sample(), 1'b1);
        for (int i = 0; i < n_words; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                load(pick_sample(), $urandom_range(0, 40) == 0);
            else if ($urandom_range(0, 4) == 0)
                ratio_at(12'($urandom));
            else
                ratio_at(12'($urandom_range(0, sb.trace_len)));
        end
    endtask

    initial
    begin
        sb = new();
        quiet = 0;
        hold_req = 0;
        zero_run = 0;
        silent_cycles = 0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, each status, ignored fields, wrap of the position.
        write_reg(REG_SPLIT, 32'd2);
        load(16'h8000, 1'b1);
        load(16'h7FFF);
        repeat (4) load(16'h0000);
        load(16'h0001);
        load(16'hFFFF);
        ratio_at(12'd0);
        ratio_at(12'd2);
        ratio_at(12'd4);
        ratio_at(12'd5);
        ratio_at(12'hFFF);
        load(16'h0000, 1'b1);
        ratio_at(12'd0);
        repeat (3) load(16'h0000);
        ratio_at(12'd0);
        wait_idle();
        write_reg(REG_MODE, 32'd1);
        write_reg(REG_LONG, 32'd0);
        write_reg(REG_SHORT, 32'd2047);
        load(16'h0000, 1'b1);
        load(16'h1234);
        ratio_at(12'd0);
        ratio_at(12'd1);
        ratio_at(12'd2);
        wait_idle();
        write_reg(REG_LONG, 32'd2047);
        write_reg(REG_SHORT, 32'd0);
        write_reg(REG_SPLIT, 32'd2047);
        ratio_at(12'd0);

        // Mid-size windows reaching the end of a short trace.
        wait_idle();
        write_reg(REG_MODE, 32'd0);
        write_reg(REG_SPLIT, 32'd30);
        load(pick_sample(), 1'b1);
        repeat (63) load(pick_sample());
        ratio_at(12'd0);
        ratio_at(12'd4);
        ratio_at(12'd5);
        wait_idle();
        write_reg(REG_MODE, 32'd1);
        write_reg(REG_LONG, 32'd60);
        write_reg(REG_SHORT, 32'd1);
        ratio_at(12'd4);
        ratio_at(12'd5);
        wait_idle();
        write_reg(REG_SHORT, 32'd60);
        ratio_at(12'd0);

        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 10)
                quiet = 1;
            random_phase(40);
            // Once, the result side stalls while ratio words keep coming.
            if (ph == 4)
            begin
                hold_req = 1;
                repeat (12) ratio_at(12'($urandom_range(0, sb.trace_len)));
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
